[hw/rtl/rvx_pkg.sv]
// Package for the RV32I executor: types, opcodes, instruction kinds and helpers.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps
package rvx_pkg;

  localparam int unsigned MemAddrBits = 16;
  localparam int unsigned MemWords    = 2 ** (MemAddrBits - 2);
  localparam int unsigned WordIdxBits = MemAddrBits - 2;

  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpJal    = 7'h6F;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpImm    = 7'h13;
  localparam logic [6:0] OpReg    = 7'h33;
  localparam logic [6:0] OpSystem = 7'h73;
  localparam logic [31:0] EcallWord = 32'h0000_0073;
  localparam logic [31:0] JalrMask  = 32'hFFFF_FFFE;

  typedef enum logic [5:0] {
    KLui = 6'd0, KAuipc, KJal, KJalr, KBeq, KBne, KBlt, KBge, KBltu, KBgeu,
    KLb, KLh, KLw, KLbu, KLhu, KSb, KSh, KSw, KAddi, KSlti, KSltiu, KXori,
    KOri, KAndi, KSlli, KSrli, KSrai, KAdd, KSub, KSll, KSlt, KSltu, KXor,
    KSrl, KSra, KOr, KAnd, KEcall, KCsrrw, KCsrrs, KCsrrc, KCsrrwi,
    KCsrrsi, KCsrrci, KUnknown
  } kind_e;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [5:0]  instr_kind;
    logic        reg_written;
    logic [4:0]  write_index;
    logic [31:0] write_value;
    logic        halted;
    logic [31:0] exit_code;
  } result_t;

  // Byte-lane write request to the word-wide data memory, two words per access.
  typedef struct packed {
    logic                   en;
    logic [WordIdxBits-1:0] idx0;
    logic [WordIdxBits-1:0] idx1;
    logic [3:0]             be0;
    logic [3:0]             be1;
    logic [31:0]            d0;
    logic [31:0]            d1;
  } mem_wr_t;

  function automatic logic [63:0] lane_place(input logic [31:0] v, input logic [1:0] off);
    logic [63:0] r;
    r = {32'd0, v} << {off, 3'b000};
    return r;
  endfunction

  function automatic logic [7:0] lane_mask(input logic [3:0] m, input logic [1:0] off);
    logic [7:0] r;
    r = {4'd0, m} << off;
    return r;
  endfunction

endpackage

[hw/rtl/rvx_if.sv]
// Valid/ready channel interfaces for the executor's input and output payloads.
// Depends on nothing; the payload fields are fixed in each interface.
`timescale 1ns / 1ps
interface rvx_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] instruction;
  logic [31:0] preload_address;
  logic [31:0] preload_data;
  modport source (output valid, operation, instruction, preload_address, preload_data,
                  input ready);
  modport sink (input valid, operation, instruction, preload_address, preload_data,
                output ready);
endinterface

interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [5:0]  instr_kind;
  logic        reg_written;
  logic [4:0]  write_index;
  logic [31:0] write_value;
  logic        halted;
  logic [31:0] exit_code;
  modport source (output valid, next_pc, instr_kind, reg_written, write_index, write_value,
                  halted, exit_code, input ready);
  modport sink (input valid, next_pc, instr_kind, reg_written, write_index, write_value,
                halted, exit_code, output ready);
endinterface

[hw/rtl/rvx_dmem.sv]
// Data memory: two word banks (even and odd words) so an unaligned access reads two words.
// Depends on rvx_pkg.
`timescale 1ns / 1ps
module rvx_dmem
  import rvx_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [WordIdxBits-1:0] rd_idx0_i,
  input  logic [WordIdxBits-1:0] rd_idx1_i,
  input  mem_wr_t                wr_i,
  output logic [31:0]            rd0_o,
  output logic [31:0]            rd1_o
);
  localparam int unsigned BankBits = WordIdxBits - 1;
  logic [31:0] even_q [MemWords/2];
  logic [31:0] odd_q  [MemWords/2];
  logic [31:0] ev_rd_q, od_rd_q;
  logic        swap_q;
  logic [WordIdxBits-1:0] ev_w, od_w;
  logic [3:0] ev_be, od_be;
  logic [31:0] ev_d, od_d;
  logic [WordIdxBits-1:0] ev_r, od_r;

  // idx0 and idx1 are consecutive, so exactly one of them is even.
  always_comb begin
    if (!rd_idx0_i[0]) begin
      ev_r = rd_idx0_i;
      od_r = rd_idx1_i;
    end else begin
      ev_r = rd_idx1_i;
      od_r = rd_idx0_i;
    end
    if (!wr_i.idx0[0]) begin
      ev_w = wr_i.idx0; ev_be = wr_i.be0; ev_d = wr_i.d0;
      od_w = wr_i.idx1; od_be = wr_i.be1; od_d = wr_i.d1;
    end else begin
      ev_w = wr_i.idx1; ev_be = wr_i.be1; ev_d = wr_i.d1;
      od_w = wr_i.idx0; od_be = wr_i.be0; od_d = wr_i.d0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      ev_rd_q <= even_q[ev_r[WordIdxBits-1:1]];
      od_rd_q <= odd_q[od_r[WordIdxBits-1:1]];
      swap_q  <= rd_idx0_i[0];
    end
    if (wr_i.en) begin
      for (int b = 0; b < 4; b++) begin
        if (ev_be[b]) even_q[ev_w[WordIdxBits-1:1]][8*b +: 8] <= ev_d[8*b +: 8];
        if (od_be[b]) odd_q[od_w[WordIdxBits-1:1]][8*b +: 8] <= od_d[8*b +: 8];
      end
    end
  end

  assign rd0_o = swap_q ? od_rd_q : ev_rd_q;
  assign rd1_o = swap_q ? ev_rd_q : od_rd_q;
  logic unused_bank;
  assign unused_bank = (BankBits == 0);
endmodule

[hw/rtl/rvx_csr.sv]
// CSR store: 4096 words, one synchronous read port and one write port, cleared by a sweep.
// Depends on rvx_pkg.
`timescale 1ns / 1ps
module rvx_csr
  import rvx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rd_en_i,
  input  logic [11:0] rd_addr_i,
  input  logic        wr_en_i,
  input  logic [11:0] wr_addr_i,
  input  logic [31:0] wr_data_i,
  output logic [31:0] rd_data_o,
  output logic        busy_o
);
  logic [31:0] mem_q [4096];
  logic [12:0] clr_q;
  logic        we;
  logic [11:0] wa;
  logic [31:0] wd;

  assign busy_o = !clr_q[12];
  always_comb begin
    if (busy_o) begin
      we = 1'b1; wa = clr_q[11:0]; wd = '0;
    end else begin
      we = wr_en_i; wa = wr_addr_i; wd = wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (busy_o) begin
      clr_q <= clr_q + 13'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) rd_data_o <= mem_q[rd_addr_i];
    if (we) mem_q[wa] <= wd;
  end
endmodule

[hw/rtl/rvx_exec.sv]
// Execute datapath: decode, ALU, branch, load align and store lane placement.
// Depends on rvx_pkg.
`timescale 1ns / 1ps
module rvx_exec
  import rvx_pkg::*;
(
  input  logic [31:0] ins_i,
  input  logic [31:0] pc_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] csr_old_i,
  input  logic [31:0] m0_i,
  input  logic [31:0] m1_i,
  input  logic [1:0]  off_i,
  output kind_e       kind_o,
  output logic        has_rd_o,
  output logic [31:0] wval_o,
  output logic [31:0] npc_o,
  output logic        csr_we_o,
  output logic [31:0] csr_wd_o,
  output logic [31:0] st_data_o,
  output logic [3:0]  st_mask_o
);
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_b, imm_j, zimm, ld, up;
  logic [63:0] pair;
  logic [4:0]  sh;
  logic        slt_i, sltu_i, slt_r, sltu_r, take;

  assign op = ins_i[6:0];
  assign f3 = ins_i[14:12];
  assign f7 = ins_i[31:25];
  assign imm_i = {{20{ins_i[31]}}, ins_i[31:20]};
  assign imm_b = {{20{ins_i[31]}}, ins_i[7], ins_i[30:25], ins_i[11:8], 1'b0};
  assign imm_j = {{12{ins_i[31]}}, ins_i[19:12], ins_i[20], ins_i[30:21], 1'b0};
  assign zimm  = {27'd0, ins_i[19:15]};
  assign up    = {ins_i[31:12], 12'd0};
  assign pair  = {m1_i, m0_i} >> {off_i, 3'b000};
  assign ld    = pair[31:0];
  assign sh    = ins_i[24:20];
  assign slt_i  = $signed(a_i) < $signed(imm_i);
  assign sltu_i = a_i < imm_i;
  assign slt_r  = $signed(a_i) < $signed(b_i);
  assign sltu_r = a_i < b_i;

  always_comb begin
    kind_o = KUnknown; has_rd_o = 1'b1; wval_o = '0; npc_o = pc_i + 32'd4;
    csr_we_o = 1'b0; csr_wd_o = '0; st_data_o = b_i; st_mask_o = 4'b0000; take = 1'b0;
    unique case (op)
      OpLui:   begin kind_o = KLui; wval_o = up; end
      OpAuipc: begin kind_o = KAuipc; wval_o = pc_i + up; end
      OpJal:   begin kind_o = KJal; wval_o = pc_i + 32'd4; npc_o = pc_i + imm_j; end
      OpJalr:  begin
        kind_o = KJalr; wval_o = pc_i + 32'd4; npc_o = (a_i + imm_i) & JalrMask;
      end
      OpBranch: begin
        has_rd_o = 1'b0;
        unique case (f3)
          3'd0: begin kind_o = KBeq;  take = a_i == b_i; end
          3'd1: begin kind_o = KBne;  take = a_i != b_i; end
          3'd4: begin kind_o = KBlt;  take = slt_r; end
          3'd5: begin kind_o = KBge;  take = !slt_r; end
          3'd6: begin kind_o = KBltu; take = sltu_r; end
          3'd7: begin kind_o = KBgeu; take = !sltu_r; end
          default: take = 1'b0;
        endcase
        if (take) npc_o = pc_i + imm_b;
      end
      OpLoad: begin
        unique case (f3)
          3'd0: begin kind_o = KLb;  wval_o = {{24{ld[7]}}, ld[7:0]}; end
          3'd1: begin kind_o = KLh;  wval_o = {{16{ld[15]}}, ld[15:0]}; end
          3'd2: begin kind_o = KLw;  wval_o = ld; end
          3'd4: begin kind_o = KLbu; wval_o = {24'd0, ld[7:0]}; end
          3'd5: begin kind_o = KLhu; wval_o = {16'd0, ld[15:0]}; end
          default: has_rd_o = 1'b0;
        endcase
      end
      OpStore: begin
        has_rd_o = 1'b0;
        unique case (f3)
          3'd0: begin kind_o = KSb; st_mask_o = 4'b0001; end
          3'd1: begin kind_o = KSh; st_mask_o = 4'b0011; end
          3'd2: begin kind_o = KSw; st_mask_o = 4'b1111; end
          default: st_mask_o = 4'b0000;
        endcase
      end
      OpImm: begin
        unique case (f3)
          3'd0: begin kind_o = KAddi;  wval_o = a_i + imm_i; end
          3'd2: begin kind_o = KSlti;  wval_o = {31'd0, slt_i}; end
          3'd3: begin kind_o = KSltiu; wval_o = {31'd0, sltu_i}; end
          3'd4: begin kind_o = KXori;  wval_o = a_i ^ imm_i; end
          3'd6: begin kind_o = KOri;   wval_o = a_i | imm_i; end
          3'd7: begin kind_o = KAndi;  wval_o = a_i & imm_i; end
          3'd1: begin kind_o = KSlli;  wval_o = a_i << sh; end
          default: begin
            if (f7[6:5] == 2'b00) begin
              kind_o = KSrli; wval_o = a_i >> sh;
            end else begin
              kind_o = KSrai; wval_o = 32'($signed(a_i) >>> sh);
            end
          end
        endcase
      end
      OpReg: begin
        unique case (f3)
          3'd0: begin
            if (f7 == 7'd0) begin kind_o = KAdd; wval_o = a_i + b_i; end
            else begin kind_o = KSub; wval_o = a_i - b_i; end
          end
          3'd1: begin kind_o = KSll;  wval_o = a_i << b_i[4:0]; end
          3'd2: begin kind_o = KSlt;  wval_o = {31'd0, slt_r}; end
          3'd3: begin kind_o = KSltu; wval_o = {31'd0, sltu_r}; end
          3'd4: begin kind_o = KXor;  wval_o = a_i ^ b_i; end
          3'd5: begin
            if (f7 == 7'd0) begin kind_o = KSrl; wval_o = a_i >> b_i[4:0]; end
            else begin kind_o = KSra; wval_o = 32'($signed(a_i) >>> b_i[4:0]); end
          end
          3'd6: begin kind_o = KOr;   wval_o = a_i | b_i; end
          default: begin kind_o = KAnd; wval_o = a_i & b_i; end
        endcase
      end
      OpSystem: begin
        if (ins_i == EcallWord) begin
          kind_o = KEcall; has_rd_o = 1'b0; npc_o = pc_i;
        end else begin
          wval_o = csr_old_i; csr_we_o = 1'b1;
          unique case (f3)
            3'd1: begin kind_o = KCsrrw;  csr_wd_o = a_i; end
            3'd2: begin kind_o = KCsrrs;  csr_wd_o = csr_old_i | a_i; end
            3'd3: begin kind_o = KCsrrc;  csr_wd_o = csr_old_i & ~a_i; end
            3'd5: begin kind_o = KCsrrwi; csr_wd_o = zimm; end
            3'd6: begin kind_o = KCsrrsi; csr_wd_o = csr_old_i | zimm; end
            3'd7: begin kind_o = KCsrrci; csr_wd_o = csr_old_i & ~zimm; end
            default: begin has_rd_o = 1'b0; csr_we_o = 1'b0; end
          endcase
        end
      end
      default: has_rd_o = 1'b0;
    endcase
  end
endmodule

[hw/rtl/rv32i_instruction_executor_core.sv]
// Top level of the RV32I executor: control, register file, memories and output register.
// Depends on rvx_pkg, rvx_if, rvx_dmem, rvx_csr and rvx_exec.
`timescale 1ns / 1ps
// Channel | Dir | Payload
// in_if   | in  | operation, instruction, preload_address, preload_data
// out_if  | out | next_pc, instr_kind, reg_written, write_index, write_value, halted, exit_code
// Each transaction passes through stage one, which computes the address and reads the CSR
// and data memories, and stage two, which executes, writes back and registers the result.
// A transaction is accepted only while stage two is empty, so no new one is taken until the last has left it.
// After reset, the CSR store is cleared by a sweep over all 4096 words before the first item is accepted.
// A pending result in the output register stalls stage two and with it acceptance.
module rv32i_instruction_executor_core
  import rvx_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  rvx_in_if.sink    in_if,
  rvx_out_if.source out_if
);
  logic [31:0] rf_q [32];
  logic [31:0] pc_q, exit_q;
  logic        halt_q;
  logic        s1_q;
  logic        op_q;
  logic [31:0] ins_q, pa_q, pd_q, a_q, b_q, addr_q;
  result_t     res_q;
  logic        ov_q;

  logic        csr_busy, acc, fire;
  logic [31:0] a_now, b_now, ea, csr_old, m0, m1;
  logic [WordIdxBits-1:0] i0, i1;
  kind_e       kind;
  logic        has_rd, csr_we, do_wr;
  logic [31:0] wval, npc, csr_wd, st_data;
  logic [3:0]  st_mask;
  logic [63:0] st_lanes;
  logic [7:0]  st_be;
  mem_wr_t     wr;
  result_t     res_d;

  // Stage two fires when the output register is free or being emptied.
  assign fire = s1_q && (!ov_q || out_if.ready);
  assign in_if.ready = !csr_busy && !s1_q;
  assign acc = in_if.valid && in_if.ready;

  assign a_now = rf_q[in_if.instruction[19:15]];
  assign b_now = rf_q[in_if.instruction[24:20]];
  always_comb begin
    if (in_if.operation) begin
      ea = in_if.preload_address;
    end else if (in_if.instruction[6:0] == OpStore) begin
      ea = a_now + {{20{in_if.instruction[31]}}, in_if.instruction[31:25],
                    in_if.instruction[11:7]};
    end else begin
      ea = a_now + {{20{in_if.instruction[31]}}, in_if.instruction[31:20]};
    end
  end
  assign i0 = ea[MemAddrBits-1:2];
  assign i1 = i0 + 1'b1;

  rvx_dmem u_dmem (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_idx0_i (i0),
    .rd_idx1_i (i1),
    .wr_i      (wr),
    .rd0_o     (m0),
    .rd1_o     (m1)
  );

  rvx_csr u_csr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (acc),
    .rd_addr_i (in_if.instruction[31:20]),
    .wr_en_i   (fire && !op_q && !halt_q && csr_we),
    .wr_addr_i (ins_q[31:20]),
    .wr_data_i (csr_wd),
    .rd_data_o (csr_old),
    .busy_o    (csr_busy)
  );

  rvx_exec u_exec (
    .ins_i     (ins_q),
    .pc_i      (pc_q),
    .a_i       (a_q),
    .b_i       (b_q),
    .csr_old_i (csr_old),
    .m0_i      (m0),
    .m1_i      (m1),
    .off_i     (addr_q[1:0]),
    .kind_o    (kind),
    .has_rd_o  (has_rd),
    .wval_o    (wval),
    .npc_o     (npc),
    .csr_we_o  (csr_we),
    .csr_wd_o  (csr_wd),
    .st_data_o (st_data),
    .st_mask_o (st_mask)
  );

  // Items are strictly serialized through stage two, so memory reads never miss a write.
  always_comb begin
    if (op_q) begin
      st_lanes = lane_place(pd_q, addr_q[1:0]);
      st_be    = lane_mask(4'b1111, addr_q[1:0]);
    end else begin
      st_lanes = lane_place(st_data, addr_q[1:0]);
      st_be    = lane_mask(st_mask, addr_q[1:0]);
    end
    wr.en   = fire && (op_q || (!halt_q && st_mask != 4'b0000));
    wr.idx0 = addr_q[MemAddrBits-1:2];
    wr.idx1 = addr_q[MemAddrBits-1:2] + 1'b1;
    wr.be0  = st_be[3:0];
    wr.be1  = st_be[7:4];
    wr.d0   = st_lanes[31:0];
    wr.d1   = st_lanes[63:32];
  end

  assign do_wr = !op_q && !halt_q && has_rd && kind != KUnknown && ins_q[11:7] != 5'd0;

  always_comb begin
    res_d = '0;
    res_d.next_pc    = pc_q;
    res_d.instr_kind = KUnknown;
    res_d.halted     = halt_q;
    res_d.exit_code  = exit_q;
    if (!op_q && !halt_q) begin
      res_d.next_pc    = npc;
      res_d.instr_kind = kind;
      if (kind == KEcall) begin
        res_d.halted    = 1'b1;
        res_d.exit_code = rf_q[3];
      end
      if (do_wr) begin
        res_d.reg_written = 1'b1;
        res_d.write_index = ins_q[11:7];
        res_d.write_value = wval;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      ov_q   <= 1'b0;
      pc_q   <= '0;
      halt_q <= 1'b0;
      exit_q <= '0;
      for (int r = 0; r < 32; r++) rf_q[r] <= '0;
    end else begin
      if (acc) begin
        s1_q <= 1'b1;
      end else if (fire) begin
        s1_q <= 1'b0;
      end
      if (fire) begin
        ov_q <= 1'b1;
      end else if (out_if.ready) begin
        ov_q <= 1'b0;
      end
      if (fire) begin
        pc_q   <= res_d.next_pc;
        halt_q <= res_d.halted;
        exit_q <= res_d.exit_code;
        if (do_wr) rf_q[ins_q[11:7]] <= wval;
      end
    end
  end

  // Stage one registers; accept only happens while stage two is empty, so the register
  // file read here already holds the previous transaction's write.
  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
    if (acc) begin
      op_q   <= in_if.operation;
      ins_q  <= in_if.instruction;
      pa_q   <= in_if.preload_address;
      pd_q   <= in_if.preload_data;
      addr_q <= ea;
      a_q    <= a_now;
      b_q    <= b_now;
    end
  end

  assign out_if.valid       = ov_q;
  assign out_if.next_pc     = res_q.next_pc;
  assign out_if.instr_kind  = res_q.instr_kind;
  assign out_if.reg_written = res_q.reg_written;
  assign out_if.write_index = res_q.write_index;
  assign out_if.write_value = res_q.write_value;
  assign out_if.halted      = res_q.halted;
  assign out_if.exit_code   = res_q.exit_code;

  logic unused_pa;
  assign unused_pa = ^pa_q;
endmodule

[hw/rtl/rvx_checker.sv]
// Port-level checker for the RV32I executor, bound to the top level.
// Depends on rvx_pkg and the top level's interfaces.
`timescale 1ns / 1ps
module rvx_checker
  import rvx_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        halted_i,
  input logic        reg_written_i,
  input logic [4:0]  write_index_i,
  input logic [5:0]  instr_kind_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i) else $error("result dropped while stalled");
  a_no_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && reg_written_i |-> write_index_i != 5'd0) else $error("write to register 0");
  a_unknown_no_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && instr_kind_i == KUnknown |-> !reg_written_i) else $error("unknown wrote");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && halted_i ##1 out_valid_i |-> halted_i)
    else $error("halt cleared");
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i) else $error("accepted while busy");
endmodule

bind rv32i_instruction_executor_core rvx_checker u_rvx_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .halted_i      (out_if.halted),
  .reg_written_i (out_if.reg_written),
  .write_index_i (out_if.write_index),
  .instr_kind_i  (out_if.instr_kind)
);
